### hw/rtl/twms_pkg.sv
// Shared types, sizes and helpers for the two-window max-sum block.
package twms_pkg;

    localparam int VAL_W      = 32;
    localparam int SUM_W      = 48;
    localparam int PAIR_W     = 49;
    localparam int RES_W      = 64;
    localparam int K_W        = 11;
    localparam int CNT_W      = 17;
    localparam int WINDOW_MAX = 1024;
    localparam int RING_AW    = $clog2(WINDOW_MAX);
    localparam int ITEMS_MAX  = 65536;
    localparam int NEAR_CELLS = 4;
    localparam int NEAR_W     = $clog2(NEAR_CELLS);
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef logic signed [VAL_W-1:0]  value_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic [K_W-1:0]           klen_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [RING_AW-1:0]       ring_addr_t;
    typedef logic [NEAR_W-1:0]        near_idx_t;

    // request from the scan pipeline to the result formula unit
    typedef struct packed {
        logic  valid;
        pair_t pair;
        res_t  total;
        cnt_t  n;
    } fin_req_t;

    // zero acts as one, anything past the ring depth is clamped
    function automatic klen_t eff_k(klen_t wl);
        klen_t k;
        k = wl;
        if (wl == '0) begin
            k = klen_t'(1);
        end else if (wl > klen_t'(WINDOW_MAX)) begin
            k = klen_t'(WINDOW_MAX);
        end
        return k;
    endfunction

endpackage

### hw/rtl/twms_cell.sv
// One prefix-best history cell; shifts toward older on each retired word.
module twms_cell (
    input  logic               aclk,
    input  logic               shift_en,
    input  twms_pkg::sum_t     d_in,
    output twms_pkg::sum_t     q
);
    import twms_pkg::*;

    sum_t q_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

### hw/rtl/twms_final.sv
// Result formula unit: three stages of products, sums and final select.
module twms_final (
    input  logic                aclk,
    input  logic                aresetn,
    input  twms_pkg::fin_req_t  req,
    input  twms_pkg::klen_t     k,
    output logic                res_valid,
    output twms_pkg::res_t      res
);
    import twms_pkg::*;

    localparam int HALF_W = CNT_W - 1;

    logic [HALF_W-1:0]      k1;
    cnt_t                   k2;
    logic [2*HALF_W-1:0]    t1_prod;
    logic [2*CNT_W-1:0]     t2_prod;
    logic [2*K_W-1:0]       kk_prod;
    logic [CNT_W+K_W-1:0]   nk_prod;
    cnt_t                   two_k;

    // stage F1
    logic                   f1_valid_reg;
    logic                   f1_use_reg;
    pair_t                  f1_pair_reg;
    res_t                   f1_total_reg;
    klen_t                  f1_k_reg;
    logic [2*K_W-1:0]       f1_kk_reg;
    logic [CNT_W+K_W-1:0]   f1_nk_reg;
    logic [2*HALF_W-1:0]    f1_t1_reg;
    logic [2*CNT_W-1:0]     f1_t2_reg;

    // stage F2
    logic                   f2_valid_reg;
    logic                   f2_use_reg;
    res_t                   f2_pair_res_reg;
    res_t                   f2_total_reg;
    res_t                   f2_term_reg;

    // stage F3
    logic                   res_valid_reg;
    res_t                   res_reg;

    assign k1      = req.n[CNT_W-1:1];
    assign k2      = req.n - cnt_t'(k1);
    assign t1_prod = (k1 == '0) ? '0
                   : {HALF_W'(0), k1 - HALF_W'(1)} * {HALF_W'(0), k1};
    assign t2_prod = (k2 == '0) ? '0
                   : {CNT_W'(0), k2 - CNT_W'(1)} * {CNT_W'(0), k2};
    assign kk_prod = {K_W'(0), k} * {K_W'(0), k};
    assign nk_prod = {K_W'(0), req.n} * {CNT_W'(0), k};
    assign two_k   = CNT_W'({k, 1'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg  <= req.valid;
            f2_valid_reg  <= f1_valid_reg;
            res_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_use_reg   <= two_k <= req.n;
        f1_pair_reg  <= req.pair;
        f1_total_reg <= req.total;
        f1_k_reg     <= k;
        f1_kk_reg    <= kk_prod;
        f1_nk_reg    <= nk_prod;
        f1_t1_reg    <= t1_prod;
        f1_t2_reg    <= t2_prod;

        f2_use_reg      <= f1_use_reg;
        f2_total_reg    <= f1_total_reg;
        f2_pair_res_reg <= res_t'(f1_pair_reg) + res_t'(f1_kk_reg) + res_t'(f1_k_reg);
        f2_term_reg     <= res_t'(f1_nk_reg) - res_t'(f1_t1_reg >> 1)
                         - res_t'(f1_t2_reg >> 1);

        res_reg <= f2_use_reg ? f2_pair_res_reg : f2_total_reg + f2_term_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/twms_outq.sv
// Small result queue feeding the master side.
module twms_outq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  twms_pkg::res_t               push_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [twms_pkg::RES_W-1:0]   m_tdata
);
    import twms_pkg::*;

    res_t                 slot_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   head_reg;
    logic [OUTQ_AW-1:0]   tail_reg;
    logic [OUTQ_AW:0]     count_reg;
    logic [OUTQ_AW:0]     count_next;
    logic                 pop;

    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + (OUTQ_AW+1)'(push) - (OUTQ_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = slot_reg[head_reg];

    // credit scheme upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != (OUTQ_AW+1)'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("result queue count lost a push");

endmodule

### hw/rtl/two_window_max_sum_top.sv
// Top level: streaming scan for the best pair of non-overlapping windows.
// Throughput: one word per cycle with no bubbles while s_tready is high; at
// most OUTQ_DEPTH results may be pending before s_tready drops. A result
// reaches m_tvalid from the edge that accepts its last word through scan
// stages 1-2, formula stages F1-F3, then the result queue.
// Reset: synchronous, active low; clears counters, running sums, credits and
// the queue, and sets the window length to 1. The rings need no clearing.
module two_window_max_sum_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // window length register
    input  logic                           cfg_we,
    input  logic [twms_pkg::K_W-1:0]       cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [twms_pkg::VAL_W-1:0]     s_tdata,   // [31:0] value
    input  logic                           s_tlast,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [twms_pkg::RES_W-1:0]     m_tdata    // [63:0] result
);
    import twms_pkg::*;

    // ---------------------------------------------------------------------
    // Window length register. Effective k is clamped to 1..WINDOW_MAX.
    // ---------------------------------------------------------------------
    klen_t wlen_reg;
    klen_t k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= klen_t'(1);
        end else if (cfg_we) begin
            wlen_reg <= cfg_wdata;
        end
    end

    assign k_eff = eff_k(wlen_reg);

    // ---------------------------------------------------------------------
    // Stage 0: accept. Ring write position and word count live here; the
    // rings are read k positions back at the same edge.
    // ---------------------------------------------------------------------
    logic            s_acc;
    value_t          v_in;
    ring_addr_t      pos_reg;
    cnt_t            count_reg;
    cnt_t            count_inc;
    ring_addr_t      rd_addr;
    logic            have_old;
    logic            full_win;
    logic            near_k;
    near_idx_t       near_idx;
    logic [OUTQ_AW:0] outstanding_reg;

    assign s_acc     = s_tvalid && s_tready;
    assign v_in      = $signed(s_tdata);
    assign rd_addr   = pos_reg - k_eff[RING_AW-1:0];
    assign have_old  = count_reg >= cnt_t'(k_eff);
    assign full_win  = ({1'b0, count_reg} + (CNT_W+1)'(1)) >= (CNT_W+1)'(k_eff);
    assign count_inc = (count_reg == cnt_t'(ITEMS_MAX)) ? count_reg : count_reg + 1'b1;
    // short windows take the old prefix best from the cell chain, since the
    // ring write of that word may not have landed yet
    assign near_k    = k_eff <= klen_t'(NEAR_CELLS);
    assign near_idx  = NEAR_W'(k_eff - klen_t'(1));

    // credits: one per last word not yet delivered
    assign s_tready  = outstanding_reg < (OUTQ_AW+1)'(OUTQ_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else if (s_acc) begin
            pos_reg   <= s_tlast ? '0 : pos_reg + 1'b1;
            count_reg <= s_tlast ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_reg + (OUTQ_AW+1)'(s_acc && s_tlast)
                             - (OUTQ_AW+1)'(m_tvalid && m_tready);
        end
    end

    // ---------------------------------------------------------------------
    // Rings. Values are written at accept; prefix best is written when the
    // word leaves stage 2. A same-address read returns the older entry,
    // which is what k = WINDOW_MAX needs.
    // ---------------------------------------------------------------------
    value_t     vmem [WINDOW_MAX];
    sum_t       pmem [WINDOW_MAX];
    value_t     vrd_reg;
    sum_t       prd_reg;
    sum_t       pb_next;

    logic       p2_valid_reg;
    ring_addr_t p2_pos_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            vmem[pos_reg] <= v_in;
            vrd_reg       <= vmem[rd_addr];
            prd_reg       <= pmem[rd_addr];
        end
        if (p2_valid_reg) begin
            pmem[p2_pos_reg] <= pb_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: sliding window sum and total.
    // ---------------------------------------------------------------------
    logic       p1_valid_reg;
    value_t     p1_v_reg;
    logic       p1_last_reg;
    logic       p1_have_reg;
    logic       p1_full_reg;
    ring_addr_t p1_pos_reg;
    cnt_t       p1_n_reg;
    logic       p1_near_reg;
    near_idx_t  p1_idx_reg;

    sum_t       ws_reg;
    res_t       total_reg;
    sum_t       old_val;
    sum_t       w_next;
    res_t       total_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_v_reg    <= v_in;
            p1_last_reg <= s_tlast;
            p1_have_reg <= have_old;
            p1_full_reg <= full_win;
            p1_pos_reg  <= pos_reg;
            p1_n_reg    <= count_inc;
            p1_near_reg <= near_k;
            p1_idx_reg  <= near_idx;
        end
    end

    assign old_val    = p1_have_reg ? sum_t'(vrd_reg) : '0;
    assign w_next     = ws_reg - old_val + sum_t'(p1_v_reg);
    assign total_next = total_reg + res_t'(p1_v_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg    <= '0;
            total_reg <= '0;
        end else if (p1_valid_reg) begin
            ws_reg    <= p1_last_reg ? '0 : w_next;
            total_reg <= p1_last_reg ? '0 : total_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: prefix best and best pair. The cell chain holds prefix best
    // after the last NEAR_CELLS retired words, newest in cell 0.
    // ---------------------------------------------------------------------
    sum_t       p2_w_reg;
    res_t       p2_total_reg;
    logic       p2_last_reg;
    logic       p2_have_reg;
    logic       p2_full_reg;
    cnt_t       p2_n_reg;
    logic       p2_near_reg;
    near_idx_t  p2_idx_reg;
    sum_t       p2_pbmem_reg;

    sum_t       pb_reg;
    pair_t      pair_reg;
    sum_t       hist [NEAR_CELLS];
    sum_t       old_best;
    sum_t       w_pos;
    pair_t      cand;
    pair_t      pair_next;
    fin_req_t   fin_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            p2_w_reg     <= w_next;
            p2_total_reg <= total_next;
            p2_last_reg  <= p1_last_reg;
            p2_have_reg  <= p1_have_reg;
            p2_full_reg  <= p1_full_reg;
            p2_pos_reg   <= p1_pos_reg;
            p2_n_reg     <= p1_n_reg;
            p2_near_reg  <= p1_near_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_pbmem_reg <= prd_reg;
        end
    end

    generate
        for (genvar i = 0; i < NEAR_CELLS; i++) begin : g_hist
            if (i == 0) begin : g_head
                twms_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (p2_valid_reg),
                    .d_in     (pb_next),
                    .q        (hist[i])
                );
            end else begin : g_tail
                twms_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (p2_valid_reg),
                    .d_in     (hist[i-1]),
                    .q        (hist[i])
                );
            end
        end
    endgenerate

    always_comb begin
        if (!p2_have_reg) begin
            old_best = '0;
        end else if (p2_near_reg) begin
            old_best = hist[p2_idx_reg];
        end else begin
            old_best = p2_pbmem_reg;
        end
    end

    assign w_pos     = (p2_w_reg > '0) ? p2_w_reg : '0;
    assign cand      = pair_t'(old_best) + pair_t'(w_pos);
    assign pair_next = (p2_full_reg && (cand > pair_reg)) ? cand : pair_reg;
    assign pb_next   = (p2_full_reg && (p2_w_reg > pb_reg)) ? p2_w_reg : pb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_reg   <= '0;
            pair_reg <= '0;
        end else if (p2_valid_reg) begin
            pb_reg   <= p2_last_reg ? '0 : pb_next;
            pair_reg <= p2_last_reg ? '0 : pair_next;
        end
    end

    always_comb begin
        fin_req.valid = p2_valid_reg && p2_last_reg;
        fin_req.pair  = pair_next;
        fin_req.total = p2_total_reg;
        fin_req.n     = p2_n_reg;
    end

    // ---------------------------------------------------------------------
    // Result formula and output queue.
    // ---------------------------------------------------------------------
    logic res_valid;
    res_t res;

    twms_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (fin_req),
        .k         (k_eff),
        .res_valid (res_valid),
        .res       (res)
    );

    twms_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_seq_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (pos_reg == '0 && count_reg == '0))
        else $error("position or count not cleared after last word");

    a_sums_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_last_reg) |=> (ws_reg == '0 && total_reg == '0))
        else $error("running sums not cleared after last word");

    a_credit_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (outstanding_reg != '0))
        else $error("result pending without a credit");

endmodule
